/* sv/slr_pkg.sv */
// shared types and constants for the slope line rasterizer
// no dependencies

package slr_pkg;

  localparam int COORD_BITS = 12;
  localparam int COLOR_BITS = 8;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } slr_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SIGN
  } slr_state_t;

  typedef struct packed {
    slr_op_t                       opcode;
    logic signed [COORD_BITS-1:0]  x_start;
    logic signed [COORD_BITS-1:0]  y_start;
    logic signed [COORD_BITS-1:0]  x_end;
    logic signed [COORD_BITS-1:0]  y_end;
    logic [COLOR_BITS-1:0]         red;
    logic [COLOR_BITS-1:0]         green;
    logic [COLOR_BITS-1:0]         blue;
    logic [COLOR_BITS-1:0]         alpha;
  } slr_in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0]  point_x;
    logic signed [COORD_BITS-1:0]  point_y;
    logic [COLOR_BITS-1:0]         out_red;
    logic [COLOR_BITS-1:0]         out_green;
    logic [COLOR_BITS-1:0]         out_blue;
    logic [COLOR_BITS-1:0]         out_alpha;
    logic                          last_point;
  } slr_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic div_iter;
    logic set_slope;
    logic step;
  } slr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic dmaj_zero;
    logic div_last;
    logic out_busy;
  } slr_status_t;

endpackage

/* sv/slr_div.sv */
// iterative restoring divider, one quotient bit per cycle while iterate is high
// depends on nothing but its parameters

module slr_div #(
  parameter int COORD_W = 12,
  parameter int FRAC_W  = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              iterate,
  input  logic [COORD_W-1:0] dividend,
  input  logic [COORD_W-1:0] divisor,
  output logic [FRAC_W:0]   quotient,
  output logic              last
);

  localparam int CNT_W = $clog2(FRAC_W + 1);

  logic [COORD_W:0]   rem_r, rem_nxt;
  logic [COORD_W-1:0] den_r;
  logic [FRAC_W:0]    q_r, q_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               ge;
  logic [COORD_W:0]   diff;

  // remainder stays below the divisor after each trial subtract
  always_comb begin
    ge      = rem_r >= {1'b0, den_r};
    diff    = ge ? (rem_r - {1'b0, den_r}) : rem_r;
    rem_nxt = {diff[COORD_W-1:0], 1'b0};
    q_nxt   = {q_r[FRAC_W-1:0], ge};
    cnt_nxt = cnt_r + CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= '0;
    end else if (iterate) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, dividend};
      den_r <= divisor;
      q_r   <= '0;
    end else if (iterate) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign quotient = q_r;
  assign last     = cnt_r == CNT_W'(FRAC_W);

endmodule

/* sv/slr_ctrl.sv */
// sequencing controller: input handshake, load and divide phases
// depends on slr_pkg

module slr_ctrl
  import slr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  slr_op_t     opcode,
  input  slr_status_t status,
  output logic        in_stall,
  output slr_cmd_t    cmd
);

  slr_state_t state_r, state_nxt;
  logic       accept;

  assign in_stall = (state_r != ST_IDLE) | status.out_busy;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && opcode == OP_LOAD && !status.dmaj_zero) begin
          state_nxt = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (status.div_last) begin
          state_nxt = ST_SIGN;
        end
      end
      ST_SIGN: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.load = accept & (opcode == OP_LOAD);
        cmd.step = accept & (opcode == OP_STEP);
      end
      ST_DIVIDE: cmd.div_iter  = 1'b1;
      ST_SIGN:   cmd.set_slope = 1'b1;
      default:   cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* sv/slr_datapath.sv */
// line setup, slope divider, minor accumulator and output register
// depends on slr_pkg and slr_div

module slr_datapath
  import slr_pkg::*;
#(
  parameter int FRAC_W = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  slr_in_t     in_data,
  input  slr_cmd_t    cmd,
  input  logic        out_stall,
  output slr_status_t status,
  output logic        out_valid,
  output slr_out_t    out_data
);

  localparam int C   = COORD_BITS;
  localparam int AW  = C + FRAC_W;
  localparam int SW  = FRAC_W + 2;

  logic signed [C:0]   xs, ys, xe, ye, dx, dy, dmaj, dmin;
  logic [C:0]          adx, ady, amaj, amin;
  logic                x_major, fwd;
  logic [C-1:0]        ma0, ma1, mi0, mi1;
  logic [FRAC_W:0]     quot;
  logic                div_last;

  logic                line_active_r, out_valid_r;
  logic                x_major_r, neg_r;
  logic [C-1:0]        pos_r, stop_r;
  logic [AW-1:0]       acc_r;
  logic [SW-1:0]       slope_r, slope_nxt;
  logic [4*COLOR_BITS-1:0] color_r;
  slr_out_t            out_r, out_nxt;

  logic [C-1:0]        minor;
  logic [C:0]          pos_inc;
  logic                last;
  logic                emit;

  // endpoint setup
  always_comb begin
    xs = {in_data.x_start[C-1], in_data.x_start};
    ys = {in_data.y_start[C-1], in_data.y_start};
    xe = {in_data.x_end[C-1], in_data.x_end};
    ye = {in_data.y_end[C-1], in_data.y_end};
    dx = xe - xs;
    dy = ye - ys;
    adx = dx[C] ? (-dx) : dx;
    ady = dy[C] ? (-dy) : dy;
    // ties go to y
    x_major = adx > ady;
    if (x_major) begin
      ma0 = in_data.x_start; ma1 = in_data.x_end;
      mi0 = in_data.y_start; mi1 = in_data.y_end;
      dmaj = dx; dmin = dy; amaj = adx; amin = ady;
    end else begin
      ma0 = in_data.y_start; ma1 = in_data.y_end;
      mi0 = in_data.x_start; mi1 = in_data.x_end;
      dmaj = dy; dmin = dx; amaj = ady; amin = adx;
    end
    fwd = $signed(ma0) < $signed(ma1);
  end

  slr_div #(
    .COORD_W (C),
    .FRAC_W  (FRAC_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.load),
    .iterate  (cmd.div_iter),
    .dividend (amin[C-1:0]),
    .divisor  (amaj[C-1:0]),
    .quotient (quot),
    .last     (div_last)
  );

  assign slope_nxt = neg_r ? (-{1'b0, quot}) : {1'b0, quot};

  // step: truncate accumulator toward zero
  always_comb begin
    minor   = acc_r[AW-1:FRAC_W] + C'(acc_r[AW-1] & (|acc_r[FRAC_W-1:0]));
    pos_inc = {pos_r[C-1], pos_r} + (C+1)'(1);
    last    = $signed(pos_inc) >= $signed({stop_r[C-1], stop_r});
    emit    = cmd.step & line_active_r;

    out_nxt.point_x    = x_major_r ? pos_r : minor;
    out_nxt.point_y    = x_major_r ? minor : pos_r;
    out_nxt.out_red    = color_r[4*COLOR_BITS-1:3*COLOR_BITS];
    out_nxt.out_green  = color_r[3*COLOR_BITS-1:2*COLOR_BITS];
    out_nxt.out_blue   = color_r[2*COLOR_BITS-1:COLOR_BITS];
    out_nxt.out_alpha  = color_r[COLOR_BITS-1:0];
    out_nxt.last_point = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_active_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      priority if (cmd.load) begin
        line_active_r <= 1'b0;
      end else if (cmd.set_slope) begin
        line_active_r <= 1'b1;
      end else if (emit && last) begin
        line_active_r <= 1'b0;
      end else begin
        line_active_r <= line_active_r;
      end
      priority if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end else begin
        out_valid_r <= out_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_major_r <= x_major;
      neg_r     <= dmin[C] ^ dmaj[C];
      pos_r     <= fwd ? ma0 : ma1;
      stop_r    <= fwd ? ma1 : ma0;
      acc_r     <= {(fwd ? mi0 : mi1), {FRAC_W{1'b0}}};
      color_r   <= {in_data.red, in_data.green, in_data.blue, in_data.alpha};
    end else if (emit) begin
      acc_r <= acc_r + {{(AW-SW){slope_r[SW-1]}}, slope_r};
      pos_r <= pos_inc[C-1:0];
    end
    if (cmd.set_slope) begin
      slope_r <= slope_nxt;
    end
    if (emit) begin
      out_r <= out_nxt;
    end
  end

  assign status.dmaj_zero = (dmaj == '0);
  assign status.div_last  = div_last;
  assign status.out_busy  = out_valid_r & out_stall;
  assign out_valid        = out_valid_r;
  assign out_data         = out_r;

endmodule

/* sv/slope_line_rasterizer.sv */
// top level of the slope line rasterizer
// depends on slr_pkg, slr_ctrl and slr_datapath

// DDA line rasterizer. A load transfer (opcode OP_LOAD) latches two endpoints
// and an RGBA color, picks the major axis (x when |dx| > |dy|, ties to y) and
// computes the signed slope d_minor / d_major with FRAC_BITS fraction bits,
// truncated toward zero, on an iterative restoring divider that produces one
// quotient bit per cycle. A load therefore occupies the block through setup,
// the divide and a sign fix-up; a line whose major span is zero skips the
// divide and never emits a point. Each step transfer (opcode OP_STEP) produces
// one point starting from the endpoint with the lower major coordinate; the
// minor coordinate is the accumulator truncated toward zero, the far endpoint
// is not emitted and last_point marks the final point. A step with no active
// line is consumed without a result. Results sit in one output register; a
// new transfer is taken as long as no load is in progress and that register
// is empty or drains in the same cycle. A load replaces any line still in
// progress.

module slope_line_rasterizer
  import slr_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  slr_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output slr_out_t out_data
);

  slr_cmd_t    cmd;
  slr_status_t status;

  // controller owns the input handshake and the divide sequencing
  slr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .opcode   (in_data.opcode),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  // datapath holds line state, slope divider and the output register
  slr_datapath #(
    .FRAC_W (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_stall (out_stall),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

/* sv/slr_checker.sv */
// port-level checks for the slope line rasterizer, bound to the top level
// depends on slr_pkg

module slr_checker
  import slr_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input slr_in_t  in_data,
  input logic     out_valid,
  input logic     out_stall,
  input slr_out_t out_data
);

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  // a load never produces a result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.opcode == OP_LOAD && !(out_valid && out_stall))
      |=> !out_valid)
    else $error("result after load transfer");

  // a new result only follows an accepted step
  a_result_from_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !$past(out_valid && out_stall))
      |-> $past(in_valid && !in_stall && in_data.opcode == OP_STEP))
    else $error("result without step transfer");

endmodule

bind slope_line_rasterizer slr_checker u_slr_checker (.*);

/* tb/tb_top.sv */
// self-checking testbench for slope_line_rasterizer: line loads and point steps
// checked against a cycle-free line tracker; depends on slr_pkg and the rtl in sv/
`timescale 1ns / 100ps

module tb_top;
  import slr_pkg::*;

  localparam int FRAC = 16;
  localparam longint ONE = longint'(1) << FRAC;
  // idle tail after the final drain, sized from the load occupancy
  localparam int TAIL_CYCLES = 2 * (FRAC + 3);
  localparam int RANDOM_ITEMS = 1800;
  localparam int HOLD_CYCLES = 80;
  localparam longint LIMIT_NS = 2_000_000;

  // tracks the line being drawn and queues the points it should produce
  class raster_tracker;
    slr_out_t    pending_points[$];
    int          errors;
    int          useful;   // loads plus steps on a live line
    bit          active;
    bit          x_major;
    longint      pos;
    longint      stop_pos;
    longint      acc;
    longint      slope;
    logic [31:0] rgba;

    function new();
      errors = 0;
      useful = 0;
      active = 0;
      x_major = 0;
      pos = 0;
      stop_pos = 0;
      acc = 0;
      slope = 0;
      rgba = '0;
    endfunction

    // called for every accepted input transfer
    function void note_transfer(slr_in_t t);
      longint xs, ys, xe, ye, dx, dy;
      longint ma0, ma1, mi0, mi1, dmaj, dmin;
      longint minor, px, py;
      bit last;
      slr_out_t p;
      if (t.opcode == OP_LOAD) begin
        xs = $signed(t.x_start);
        ys = $signed(t.y_start);
        xe = $signed(t.x_end);
        ye = $signed(t.y_end);
        dx = xe - xs;
        dy = ye - ys;
        // ties go to y
        x_major = ((dx < 0) ? -dx : dx) > ((dy < 0) ? -dy : dy);
        if (x_major) begin
          ma0 = xs; ma1 = xe; mi0 = ys; mi1 = ye;
        end else begin
          ma0 = ys; ma1 = ye; mi0 = xs; mi1 = xe;
        end
        dmaj = ma1 - ma0;
        dmin = mi1 - mi0;
        rgba = {t.red, t.green, t.blue, t.alpha};
        useful++;
        if (dmaj == 0) begin
          active = 0;
          slope = 0;
          pos = ma0;
          stop_pos = ma1;
          acc = mi0 * ONE;
        end else begin
          // longint division truncates toward zero
          slope = (dmin * ONE) / dmaj;
          if (ma0 < ma1) begin
            pos = ma0; stop_pos = ma1; acc = mi0 * ONE;
          end else begin
            pos = ma1; stop_pos = ma0; acc = mi1 * ONE;
          end
          active = 1;
        end
      end else if (active) begin
        useful++;
        minor = acc / ONE;
        px = x_major ? pos : minor;
        py = x_major ? minor : pos;
        last = (pos + 1) >= stop_pos;
        p.point_x = px[COORD_BITS-1:0];
        p.point_y = py[COORD_BITS-1:0];
        {p.out_red, p.out_green, p.out_blue, p.out_alpha} = rgba;
        p.last_point = last;
        pending_points.push_back(p);
        acc += slope;
        pos += 1;
        if (last) active = 0;
      end
    endfunction

    function void compare(string field, int expv, int actv);
      if (expv != actv) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, expv, actv);
      end
    endfunction

    // called for every accepted result transfer
    function void check_point(slr_out_t got);
      slr_out_t want;
      if (pending_points.size() == 0) begin
        errors++;
        $display("%0t: unexpected point, expected none actual x=%0d y=%0d", $time,
                 $signed(got.point_x), $signed(got.point_y));
        return;
      end
      want = pending_points.pop_front();
      compare("point_x", $signed(want.point_x), $signed(got.point_x));
      compare("point_y", $signed(want.point_y), $signed(got.point_y));
      compare("out_red", want.out_red, got.out_red);
      compare("out_green", want.out_green, got.out_green);
      compare("out_blue", want.out_blue, got.out_blue);
      compare("out_alpha", want.out_alpha, got.out_alpha);
      compare("last_point", want.last_point, got.last_point);
    endfunction
  endclass

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  slr_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  slr_out_t out_data;

  raster_tracker board = new();

  // idling controls shared between the sender and the receiver
  bit send_idle;
  bit recv_idle;
  bit hold_flag;

  slope_line_rasterizer #(
    .FRAC_BITS(FRAC)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #(LIMIT_NS);
    $display("tb_top: FAIL");
    $finish;
  end

  // result monitor: values read right after the edge are the sampled ones
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_point(out_data);
  end

  // receiver: random stall bursts, plus one long hold on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_flag) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_flag = 1'b0;
      end else if (recv_idle && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // offer one item and hold it until the transfer; valid stays up afterwards
  // so back-to-back items never lower and raise it in the same step
  task automatic send_item(input slr_in_t item);
    if (send_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_transfer(item);
  endtask

  function automatic int clamp_coord(int v);
    if (v < -2048) return -2048;
    if (v > 2047) return 2047;
    return v;
  endfunction

  task automatic load_line(input int xs, input int ys, input int xe, input int ye,
                           input logic [31:0] rgba);
    slr_in_t item;
    item.opcode  = OP_LOAD;
    item.x_start = xs[COORD_BITS-1:0];
    item.y_start = ys[COORD_BITS-1:0];
    item.x_end   = xe[COORD_BITS-1:0];
    item.y_end   = ye[COORD_BITS-1:0];
    {item.red, item.green, item.blue, item.alpha} = rgba;
    send_item(item);
  endtask

  // step items carry random junk in the unused fields
  task automatic step_line(input int count);
    slr_in_t item;
    repeat (count) begin
      item = slr_in_t'({$urandom, $urandom, $urandom});
      item.opcode = OP_STEP;
      send_item(item);
    end
  endtask

  // pause the sender until every queued point has come back
  task automatic drain_points();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_points.size() != 0) @(posedge clk);
  endtask

  initial begin
    int kind;
    int xs, ys, span, dx, dy;
    bit held, paused;
    slr_in_t junk;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    send_idle = 1'b1;
    recv_idle = 1'b1;
    hold_flag = 1'b0;
    held      = 1'b0;
    paused    = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed part
    step_line(1);                                   // step with no line after reset
    load_line(7, -3, 7, -3, 32'hFFFF_FFFF);         // identical endpoints, zero length
    step_line(1);
    load_line(-2048, -2048, 2047, 0, 32'h0000_0000); // x major, full-width span
    step_line(3);
    load_line(2047, 2047, -2048, -2048, 32'hFF00_FF00); // tie goes to y, reversed, abandons
    step_line(2);
    load_line(0, 0, 3, -1, 32'h00FF_00FF);          // negative slope truncates toward zero
    step_line(4);                                   // last one runs past the end
    load_line(-1, 5, 1, -5, 32'h1234_5678);         // y major, starts from the far end
    step_line(2);
    load_line(0, 0, 1, 0, 32'h8080_8080);           // single-point line
    step_line(2);
    drain_points();

    // random part: mostly complete short lines, some long ones, some noise
    while (board.useful < RANDOM_ITEMS) begin
      // idling comes in phases, and stops for the final stretch
      send_idle = (board.useful < RANDOM_ITEMS - 250) && ((board.useful / 150) % 4 != 3);
      recv_idle = send_idle;

      if (!held && board.useful > 500) begin
        // long receiver hold while steps keep coming, so the input stalls
        held = 1'b1;
        load_line(-20, 3, 25, 11, $urandom);
        hold_flag = 1'b1;
        step_line(45);
      end else if (!paused && board.useful > 1000) begin
        paused = 1'b1;
        drain_points();
      end

      kind = $urandom_range(0, 99);
      xs = $urandom_range(0, 4095) - 2048;
      ys = $urandom_range(0, 4095) - 2048;
      if (kind < 75) begin
        span = $urandom_range(0, 24);
        dx = $urandom_range(0, 2 * span) - span;
        dy = $urandom_range(0, 2 * span) - span;
        load_line(xs, ys, clamp_coord(xs + dx), clamp_coord(ys + dy), $urandom);
        // walk to the end, sometimes past it, sometimes abandon early
        if ($urandom_range(0, 9) == 0) step_line($urandom_range(0, span));
        else step_line(((dx < 0) ? -dx : dx) + ((dy < 0) ? -dy : dy) + $urandom_range(0, 2));
      end else if (kind < 85) begin
        load_line(xs, ys, $urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048,
                  $urandom);
        step_line($urandom_range(0, 30));
      end else if (kind < 87) begin
        drain_points();
      end else begin
        junk = slr_in_t'({$urandom, $urandom, $urandom});
        send_item(junk);
      end
    end

    drain_points();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending_points.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

/* slope_line_rasterizer.f */
sv/slr_pkg.sv
sv/slr_div.sv
sv/slr_ctrl.sv
sv/slr_datapath.sv
sv/slope_line_rasterizer.sv
sv/slr_checker.sv
tb/tb_top.sv
